### rtl/nnsag_pkg.sv
package nnsag_pkg;

  localparam int MAX_DIM      = 4096;
  localparam int DIM_W        = 13;
  localparam int COORD_W      = 12;
  localparam int PITCH_W      = 16;
  localparam int BPP_W        = 3;
  localparam int OFFSET_W     = 28;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int PIX_BYTES_24 = 3;
  localparam int BITS_PER_BYTE = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_DST_WIDTH  = 3'd2,
    REG_DST_HEIGHT = 3'd3,
    REG_SRC_PITCH  = 3'd4,
    REG_DST_PITCH  = 3'd5,
    REG_BPP        = 3'd6
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;        // restart: zero walk state, active if dst size nonzero
    logic deactivate;
    logic col_advance;  // add src_width to col_error, next dst column
    logic row_advance;  // new row: clear column walk, add src_height to row_error
    logic col_sub;
    logic row_sub;
    logic load_out;
  } nnsag_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic active;
    logic dst_zero;
    logic col_wrap;     // next dst column reaches dst_width
    logic row_end;      // next dst row reaches dst_height
    logic col_ge;
    logic row_ge;
    logic out_free;
  } nnsag_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DIM_W-1:0] d;
    d = v[DIM_W-1:0];
    if (32'(d) > MAX_DIM) begin
      clamp_dim = DIM_W'(MAX_DIM);
    end else begin
      clamp_dim = d;
    end
  endfunction

endpackage

### rtl/nnsag_ctrl.sv
module nnsag_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   restart,
  input  nnsag_pkg::nnsag_status_t sts,
  output nnsag_pkg::nnsag_cmd_t    cmd
);
  import nnsag_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    COL_STEP,
    ROW_STEP,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          priority if (restart) begin
            cmd.clear  = 1'b1;
            state_next = sts.dst_zero ? IDLE : EMIT;
          end else if (!sts.active) begin
            state_next = IDLE;
          end else if (sts.dst_zero) begin
            cmd.deactivate = 1'b1;
          end else if (!sts.col_wrap) begin
            cmd.col_advance = 1'b1;
            state_next      = COL_STEP;
          end else if (sts.row_end) begin
            cmd.deactivate = 1'b1;
          end else begin
            cmd.row_advance = 1'b1;
            state_next      = ROW_STEP;
          end
        end
      end
      COL_STEP: begin
        if (sts.col_ge) begin
          cmd.col_sub = 1'b1;
        end else begin
          state_next = EMIT;
        end
      end
      ROW_STEP: begin
        if (sts.row_ge) begin
          cmd.row_sub = 1'b1;
        end else begin
          state_next = EMIT;
        end
      end
      EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/nnsag_datapath.sv
module nnsag_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [nnsag_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nnsag_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  nnsag_pkg::nnsag_cmd_t                 cmd,
  output nnsag_pkg::nnsag_status_t              sts,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nnsag_pkg::COORD_W-1:0]         src_col,
  output logic [nnsag_pkg::COORD_W-1:0]         src_row,
  output logic [nnsag_pkg::COORD_W-1:0]         dst_col,
  output logic [nnsag_pkg::COORD_W-1:0]         dst_row,
  output logic [nnsag_pkg::OFFSET_W-1:0]        src_offset,
  output logic [nnsag_pkg::OFFSET_W-1:0]        dst_offset,
  output logic                                  last
);
  import nnsag_pkg::*;

  logic [DIM_W-1:0]   src_width, src_height, dst_width, dst_height;
  logic [PITCH_W-1:0] src_pitch, dst_pitch;
  logic [BPP_W-1:0]   bytes_per_pixel;

  logic [DIM_W-1:0]   col_error, row_error;
  logic [COORD_W-1:0] cur_src_col, cur_src_row, cur_dst_col, cur_dst_row;
  logic               active;

  logic [DIM_W-1:0]   next_col, next_row;
  logic [DIM_W:0]     col_sum, row_sum;
  logic               last_now;
  logic [OFFSET_W:0]  src_off_full, dst_off_full;

  assign next_col = {1'b0, cur_dst_col} + DIM_W'(1);
  assign next_row = {1'b0, cur_dst_row} + DIM_W'(1);
  assign col_sum  = {1'b0, col_error} + {1'b0, src_width};
  assign row_sum  = {1'b0, row_error} + {1'b0, src_height};
  assign last_now = (next_col >= dst_width) && (next_row >= dst_height);

  assign src_off_full = (OFFSET_W+1)'(cur_src_row * src_pitch)
                      + (OFFSET_W+1)'(cur_src_col * bytes_per_pixel);
  assign dst_off_full = (OFFSET_W+1)'(cur_dst_row * dst_pitch)
                      + (OFFSET_W+1)'(cur_dst_col * bytes_per_pixel);

  assign sts.active   = active;
  assign sts.dst_zero = (dst_width == '0) || (dst_height == '0);
  assign sts.col_wrap = next_col >= dst_width;
  assign sts.row_end  = next_row >= dst_height;
  assign sts.col_ge   = col_error >= dst_width;
  assign sts.row_ge   = row_error >= dst_height;
  assign sts.out_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width       <= '0;
      src_height      <= '0;
      dst_width       <= '0;
      dst_height      <= '0;
      src_pitch       <= '0;
      dst_pitch       <= '0;
      bytes_per_pixel <= BPP_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width       <= clamp_dim(cfg_data);
        REG_SRC_HEIGHT: src_height      <= clamp_dim(cfg_data);
        REG_DST_WIDTH:  dst_width       <= clamp_dim(cfg_data);
        REG_DST_HEIGHT: dst_height      <= clamp_dim(cfg_data);
        REG_SRC_PITCH:  src_pitch       <= cfg_data[PITCH_W-1:0];
        REG_DST_PITCH:  dst_pitch       <= cfg_data[PITCH_W-1:0];
        REG_BPP:        bytes_per_pixel <= cfg_data[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_error   <= '0;
      row_error   <= '0;
      cur_src_col <= '0;
      cur_src_row <= '0;
      cur_dst_col <= '0;
      cur_dst_row <= '0;
      active      <= 1'b0;
    end else begin
      if (cmd.clear) begin
        col_error   <= '0;
        row_error   <= '0;
        cur_src_col <= '0;
        cur_src_row <= '0;
        cur_dst_col <= '0;
        cur_dst_row <= '0;
        active      <= !sts.dst_zero;
      end
      if (cmd.deactivate) begin
        active <= 1'b0;
      end
      if (cmd.col_advance) begin
        col_error   <= col_sum[DIM_W-1:0];
        cur_dst_col <= next_col[COORD_W-1:0];
      end
      if (cmd.row_advance) begin
        col_error   <= '0;
        cur_src_col <= '0;
        cur_dst_col <= '0;
        row_error   <= row_sum[DIM_W-1:0];
        cur_dst_row <= next_row[COORD_W-1:0];
      end
      if (cmd.col_sub) begin
        col_error   <= col_error - dst_width;
        cur_src_col <= cur_src_col + COORD_W'(1);
      end
      if (cmd.row_sub) begin
        row_error   <= row_error - dst_height;
        cur_src_row <= cur_src_row + COORD_W'(1);
      end
      if (cmd.load_out && last_now) begin
        active <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      src_col    <= cur_src_col;
      src_row    <= cur_src_row;
      dst_col    <= cur_dst_col;
      dst_row    <= cur_dst_row;
      src_offset <= src_off_full[OFFSET_W-1:0];
      dst_offset <= dst_off_full[OFFSET_W-1:0];
      last       <= last_now;
    end
  end

endmodule

### rtl/nearest_neighbor_scale_addr_gen.sv
// Nearest-neighbor stretch-blit address generator.
// Steps: restart goes from IDLE to EMIT; advance goes through COL_STEP or ROW_STEP, doing k
//   error-accumulator subtracts (about src/dst ratio), one a cycle, then EMIT loads the result.
// Throughput: one transaction at a time; the next is taken once the result is registered,
//   the output register lets it proceed while that result waits.
// Reset (rst, synchronous): idle, walk state zero, registers zero except bytes_per_pixel = 1.
module nearest_neighbor_scale_addr_gen (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [nnsag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nnsag_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [nnsag_pkg::COORD_W-1:0]      src_col,
  output logic [nnsag_pkg::COORD_W-1:0]      src_row,
  output logic [nnsag_pkg::COORD_W-1:0]      dst_col,
  output logic [nnsag_pkg::COORD_W-1:0]      dst_row,
  output logic [nnsag_pkg::OFFSET_W-1:0]     src_offset,
  output logic [nnsag_pkg::OFFSET_W-1:0]     dst_offset,
  output logic                               last
);
  import nnsag_pkg::*;

  nnsag_cmd_t    cmd;
  nnsag_status_t sts;

  nnsag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (restart),
    .sts      (sts),
    .cmd      (cmd)
  );

  nnsag_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .src_col    (src_col),
    .src_row    (src_row),
    .dst_col    (dst_col),
    .dst_row    (dst_row),
    .src_offset (src_offset),
    .dst_offset (dst_offset),
    .last       (last)
  );

endmodule
